### src/khmer_cluster_normalizer_defines.svh
// Assertion helpers for the cluster normalizer checker.
`ifndef KHMER_CLUSTER_NORMALIZER_DEFINES_SVH
`define KHMER_CLUSTER_NORMALIZER_DEFINES_SVH

// same-cycle implication
`define KCN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kcn check failed");

// next-cycle implication
`define KCN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kcn check failed");

`endif

### src/kcn_pkg.sv
`timescale 1ns / 1ps
package kcn_pkg;

  localparam int CP_W        = 21;
  localparam int MAX_PARTS   = 63;
  localparam int STORE_DEPTH = 64;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int MAX_RESULTS = 64;
  localparam int OPS_MAX     = 4;
  localparam int OP_IDX_W    = $clog2(OPS_MAX);
  localparam int OP_W        = OP_IDX_W + 1;

  localparam logic [CP_W-1:0] CP_ZWSP     = 21'h0200B;
  localparam logic [CP_W-1:0] CP_E        = 21'h017C1;
  localparam logic [CP_W-1:0] CP_I        = 21'h017B8;
  localparam logic [CP_W-1:0] CP_AA       = 21'h017B6;
  localparam logic [CP_W-1:0] CP_OE       = 21'h017BE;
  localparam logic [CP_W-1:0] CP_AU       = 21'h017C4;
  localparam logic [CP_W-1:0] CP_COENG    = 21'h017D2;
  localparam logic [CP_W-1:0] CP_RO       = 21'h0179A;
  localparam logic [CP_W-1:0] CP_KA       = 21'h01780;
  localparam logic [CP_W-1:0] CP_QA       = 21'h017A2;
  localparam logic [CP_W-1:0] CP_BASE_HI  = 21'h017B3;
  localparam logic [CP_W-1:0] CP_VOW_HI   = 21'h017C5;
  localparam logic [CP_W-1:0] CP_REG_A    = 21'h017C9;
  localparam logic [CP_W-1:0] CP_REG_B    = 21'h017CA;
  localparam logic [CP_W-1:0] CP_SIGN_LO  = 21'h017C6;
  localparam logic [CP_W-1:0] CP_SIGN_HI  = 21'h017D1;
  localparam logic [CP_W-1:0] CP_SIGN_X   = 21'h017D3;
  localparam logic [CP_W-1:0] CP_SIGN_Y   = 21'h017DD;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0] part_code_point;
    logic [CP_W-1:0] follow_code_point;
    logic            has_follow;
    logic            last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] follow;
    logic            has;
  } part_t;

  localparam int PART_W = $bits(part_t);

  typedef struct packed {
    logic            push;
    logic            fin;
    part_t           part;
  } emit_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    part_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    CLS_OTHER, CLS_BASE, CLS_COENG, CLS_REG, CLS_VOWEL, CLS_SIGN
  } class_e;

  typedef enum logic [1:0] {HELD_NONE, HELD_E, HELD_COENG} held_e;

  typedef enum logic [1:0] {RET_ADD, RET_EMIT, RET_NEXT, RET_FIN} ret_e;

  typedef enum logic [3:0] {
    S_IDLE, S_OP, S_FL_RD, S_FL_EM, S_INS, S_INS_CMP, S_EMIT, S_FULL, S_FIN
  } seq_state_e;

  function automatic class_e char_class(input logic [CP_W-1:0] c);
    class_e k;
    if (c >= CP_KA && c <= CP_BASE_HI) k = CLS_BASE;
    else if (c == CP_COENG) k = CLS_COENG;
    else if (c == CP_REG_A || c == CP_REG_B) k = CLS_REG;
    else if (c >= CP_AA && c <= CP_VOW_HI) k = CLS_VOWEL;
    else if ((c >= CP_SIGN_LO && c <= CP_SIGN_HI) || c == CP_SIGN_X || c == CP_SIGN_Y)
      k = CLS_SIGN;
    else k = CLS_OTHER;
    return k;
  endfunction

  // rank order: coeng, coeng-ro, register, vowel, sign, anything else
  function automatic logic [2:0] rank_of(input part_t p);
    logic [2:0] r;
    if (p.cp == CP_COENG) begin
      r = (p.has && p.follow == CP_RO) ? 3'd1 : 3'd0;
    end else begin
      unique case (char_class(p.cp))
        CLS_REG:   r = 3'd2;
        CLS_VOWEL: r = 3'd3;
        CLS_SIGN:  r = 3'd4;
        default:   r = 3'd5;
      endcase
    end
    return r;
  endfunction

  function automatic logic goes_after(input part_t a, input part_t b);
    logic [2:0] ra;
    logic [2:0] rb;
    ra = rank_of(a);
    rb = rank_of(b);
    return (ra > rb) || (ra == rb && a.cp > b.cp);
  endfunction

  function automatic part_t mk_part(input logic [CP_W-1:0] c, input logic [CP_W-1:0] f,
                                    input logic h);
    part_t p;
    p.cp     = c;
    p.follow = f;
    p.has    = h;
    return p;
  endfunction

endpackage

### src/kcn_ram.sv
`timescale 1ns / 1ps
module kcn_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### src/kcn_out.sv
`timescale 1ns / 1ps
module kcn_out import kcn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  emit_req_t req_i,
  output logic      busy_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // one result is held back until we know whether it closes the run
  logic             pend_valid_q, pend_valid_d;
  part_t            pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q, out_item_d;
  logic [CNT_W-1:0] res_n_q, res_n_d;
  logic             free;
  logic             room;

  assign free   = !out_valid_q || out_ready_i;
  assign busy_o = pend_valid_q && !free;
  assign room   = res_n_q < CNT_W'(MAX_RESULTS);

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_item_d   = out_item_q;
    res_n_d      = res_n_q;
    if (req_i.push && room) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_item_d  = '{pend_q.cp, pend_q.follow, pend_q.has, 1'b0};
      end
      pend_valid_d = 1'b1;
      pend_d       = req_i.part;
      res_n_d      = res_n_q + CNT_W'(1);
    end else if (req_i.fin) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_item_d  = '{pend_q.cp, pend_q.follow, pend_q.has, 1'b1};
      end
      pend_valid_d = 1'b0;
      res_n_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      res_n_q      <= '0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      res_n_q      <= res_n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### src/kcn_seq.sv
`timescale 1ns / 1ps
module kcn_seq import kcn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output ram_req_t  ram_req_o,
  input  part_t     ram_rdata_i,
  output emit_req_t emit_req_o,
  input  logic      emit_busy_i
);

  seq_state_e       state_q, state_d;
  held_e            held_q, held_d;
  part_t            ops_q [OPS_MAX];
  part_t            ops_d [OPS_MAX];
  logic [OP_W-1:0]  n_ops_q, n_ops_d;
  logic             flush_end_q, flush_end_d;
  logic [OP_W-1:0]  op_idx_q, op_idx_d;
  ret_e             ret_q, ret_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] fl_idx_q, fl_idx_d;

  // decode of one input into up to two grouping ops
  held_e            hk;
  logic [CP_W-1:0]  cp;
  logic             skip;
  logic             joined;
  logic [OP_W-1:0]  n;
  part_t            acc_ops [OPS_MAX];

  part_t            cur;
  class_e           cur_class;
  logic             ops_done;
  logic             fl_done;
  logic             rd_after;
  logic [CNT_W-1:0] j_m1;

  always_comb begin
    hk     = held_q;
    cp     = in_item_i.code_point;
    skip   = 1'b0;
    joined = 1'b0;
    n      = '0;
    for (int i = 0; i < OPS_MAX; i++) acc_ops[i] = '0;
    if (hk == HELD_E) begin
      hk = HELD_NONE;
      if (cp == CP_I) begin
        acc_ops[n[OP_IDX_W-1:0]] = mk_part(CP_OE, '0, 1'b0);
        skip = 1'b1;
      end else if (cp == CP_AA) begin
        acc_ops[n[OP_IDX_W-1:0]] = mk_part(CP_AU, '0, 1'b0);
        skip = 1'b1;
      end else begin
        acc_ops[n[OP_IDX_W-1:0]] = mk_part(CP_E, '0, 1'b0);
      end
      n = n + OP_W'(1);
    end
    if (!skip && cp != CP_ZWSP) begin
      if (cp == CP_E) begin
        if (hk == HELD_COENG) begin
          acc_ops[n[OP_IDX_W-1:0]] = mk_part(CP_COENG, '0, 1'b0);
          n = n + OP_W'(1);
        end
        hk = HELD_E;
      end else begin
        if (hk == HELD_COENG) begin
          if (cp >= CP_KA && cp <= CP_QA) begin
            acc_ops[n[OP_IDX_W-1:0]] = mk_part(CP_COENG, cp, 1'b1);
            joined = 1'b1;
          end else begin
            acc_ops[n[OP_IDX_W-1:0]] = mk_part(CP_COENG, '0, 1'b0);
          end
          n  = n + OP_W'(1);
          hk = HELD_NONE;
        end
        if (!joined) begin
          if (cp == CP_COENG) begin
            hk = HELD_COENG;
          end else begin
            acc_ops[n[OP_IDX_W-1:0]] = mk_part(cp, '0, 1'b0);
            n = n + OP_W'(1);
          end
        end
      end
    end
    if (in_item_i.end_of_text) begin
      if (hk == HELD_E) begin
        acc_ops[n[OP_IDX_W-1:0]] = mk_part(CP_E, '0, 1'b0);
        n = n + OP_W'(1);
      end else if (hk == HELD_COENG) begin
        acc_ops[n[OP_IDX_W-1:0]] = mk_part(CP_COENG, '0, 1'b0);
        n = n + OP_W'(1);
      end
      hk = HELD_NONE;
    end
  end

  assign cur       = ops_q[op_idx_q[OP_IDX_W-1:0]];
  assign cur_class = char_class(cur.cp);
  assign ops_done  = op_idx_q == n_ops_q;
  assign fl_done   = fl_idx_q == count_q;
  assign rd_after  = goes_after(ram_rdata_i, cur);
  assign j_m1      = j_q - CNT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_OP;
      end
      S_OP: begin
        if (ops_done) begin
          state_d = flush_end_q ? S_FL_RD : S_FIN;
        end else begin
          unique case (cur_class)
            CLS_BASE, CLS_OTHER: state_d = S_FL_RD;
            CLS_COENG:           state_d = S_INS;
            default:             state_d = (count_q != '0) ? S_INS : S_EMIT;
          endcase
        end
      end
      S_FL_RD: begin
        if (fl_done) begin
          unique case (ret_q)
            RET_ADD:  state_d = S_INS;
            RET_EMIT: state_d = S_EMIT;
            RET_NEXT: state_d = S_OP;
            default:  state_d = S_FIN;
          endcase
        end else begin
          state_d = S_FL_EM;
        end
      end
      S_FL_EM: begin
        if (!emit_busy_i) state_d = S_FL_RD;
      end
      S_INS: begin
        state_d = (j_q <= CNT_W'(1)) ? S_FULL : S_INS_CMP;
      end
      S_INS_CMP: begin
        state_d = rd_after ? S_INS : S_FULL;
      end
      S_EMIT: begin
        if (!emit_busy_i) state_d = S_FULL;
      end
      S_FULL: begin
        state_d = (count_q >= CNT_W'(MAX_PARTS)) ? S_FL_RD : S_OP;
      end
      S_FIN: begin
        if (!emit_busy_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    held_d      = held_q;
    ops_d       = ops_q;
    n_ops_d     = n_ops_q;
    flush_end_d = flush_end_q;
    op_idx_d    = op_idx_q;
    ret_d       = ret_q;
    count_d     = count_q;
    j_d         = j_q;
    fl_idx_d    = fl_idx_q;
    in_ready_o  = 1'b0;
    ram_req_o   = '0;
    emit_req_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ops_d       = acc_ops;
          n_ops_d     = n;
          held_d      = hk;
          flush_end_d = in_item_i.end_of_text;
          op_idx_d    = '0;
        end
      end
      S_OP: begin
        fl_idx_d = '0;
        if (ops_done) begin
          ret_d = RET_FIN;
        end else begin
          unique case (cur_class)
            CLS_BASE:  ret_d = RET_ADD;
            CLS_OTHER: ret_d = RET_EMIT;
            default:   j_d   = count_q;
          endcase
        end
      end
      S_FL_RD: begin
        if (fl_done) begin
          count_d = '0;
          j_d     = '0;
          if (ret_q == RET_NEXT) op_idx_d = op_idx_q + OP_W'(1);
        end else begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = fl_idx_q[IDX_W-1:0];
        end
      end
      S_FL_EM: begin
        if (!emit_busy_i) begin
          emit_req_o.push = 1'b1;
          emit_req_o.part = ram_rdata_i;
          fl_idx_d        = fl_idx_q + CNT_W'(1);
        end
      end
      S_INS: begin
        if (j_q <= CNT_W'(1)) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = j_q[IDX_W-1:0];
          ram_req_o.wdata = cur;
          count_d         = count_q + CNT_W'(1);
        end else begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = j_m1[IDX_W-1:0];
        end
      end
      S_INS_CMP: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = j_q[IDX_W-1:0];
        if (rd_after) begin
          ram_req_o.wdata = ram_rdata_i;
          j_d             = j_m1;
        end else begin
          ram_req_o.wdata = cur;
          count_d         = count_q + CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (!emit_busy_i) begin
          emit_req_o.push = 1'b1;
          emit_req_o.part = cur;
        end
      end
      S_FULL: begin
        if (count_q >= CNT_W'(MAX_PARTS)) begin
          ret_d    = RET_NEXT;
          fl_idx_d = '0;
        end else begin
          op_idx_d = op_idx_q + OP_W'(1);
        end
      end
      S_FIN: begin
        if (!emit_busy_i) emit_req_o.fin = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= HELD_NONE;
      n_ops_q     <= '0;
      flush_end_q <= 1'b0;
      op_idx_q    <= '0;
      ret_q       <= RET_NEXT;
      count_q     <= '0;
      j_q         <= '0;
      fl_idx_q    <= '0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      n_ops_q     <= n_ops_d;
      flush_end_q <= flush_end_d;
      op_idx_q    <= op_idx_d;
      ret_q       <= ret_d;
      count_q     <= count_d;
      j_q         <= j_d;
      fl_idx_q    <= fl_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ops_q <= ops_d;
  end

endmodule

### src/khmer_cluster_normalizer.sv
`timescale 1ns / 1ps
// Khmer cluster normalizer.
// Input channel (in_valid_i / in_ready_o / in_item_i): one code point per item,
// end_of_text set on the last code point of the text to flush everything held.
// Output channel (out_valid_o / out_ready_i / out_item_o): one cluster part per
// item; last_of_run marks the final part caused by one input item.
// Each input is decoded into at most two grouping steps run by one sequencer
// over a single-port-read part store (64 x 43 bits). Parts are kept sorted as
// they arrive: each insertion walks down the store, reading each part it passes
// and writing it one place up (S_INS, S_INS_CMP). A flush reads the store once
// per part and emits each part it reads (S_FL_RD, S_FL_EM).
// in_ready_o is high only while the sequencer is idle, one item at a time.
// One result is held back until the run ends so last_of_run is known; the
// output register lets the next input be taken while the final part waits.
// A stalled receiver stalls the sequencer whenever a new result needs room.
// Reset clears the sequencer, the held vowel/coeng and the part count; the
// store itself is not cleared, only entries below the count are ever read.
module khmer_cluster_normalizer import kcn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  ram_req_t  ram_req;
  part_t     ram_rdata;
  emit_req_t emit_req;
  logic      emit_busy;

  kcn_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .emit_req_o  (emit_req),
    .emit_busy_i (emit_busy)
  );

  // sorted part store
  kcn_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (PART_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // hold-back stage plus output register
  kcn_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (emit_req),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### src/kcn_checker.sv
`timescale 1ns / 1ps
`include "khmer_cluster_normalizer_defines.svh"
module kcn_checker import kcn_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  `KCN_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(out_item_o))

  // one item at a time: busy right after an accept
  `KCN_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  `KCN_ASSERT_NOW(a_follow_zero, out_valid_o && !out_item_o.has_follow,
                  out_item_o.follow_code_point == '0)

  `KCN_ASSERT_NOW(a_follow_coeng, out_valid_o && out_item_o.has_follow,
                  out_item_o.part_code_point == CP_COENG)

endmodule

bind khmer_cluster_normalizer kcn_checker u_kcn_checker (.*);

### tb/khmer_cluster_normalizer_checker.sv
`timescale 1ns / 1ps
module khmer_cluster_normalizer_checker import kcn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  typedef struct {
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] fol;
    logic            has;
  } seg_t;

  seg_t            cluster[64];
  int              cluster_len;
  logic [CP_W-1:0] held_cp;
  held_e           held_state;
  out_item_t       parts_due[$];
  out_item_t       run_parts[$];

  function automatic int seg_rank(seg_t p);
    if (p.cp == CP_COENG) return (p.has && p.fol == CP_RO) ? 20 : 10;
    if (p.cp == CP_REG_A || p.cp == CP_REG_B) return 30;
    if (p.cp >= CP_AA && p.cp <= CP_VOW_HI) return 40;
    if ((p.cp >= CP_SIGN_LO && p.cp <= CP_SIGN_HI) || p.cp == CP_SIGN_X
        || p.cp == CP_SIGN_Y) return 50;
    return 100;
  endfunction

  function automatic int cp_kind(logic [CP_W-1:0] c);
    seg_t s;
    s.cp = c; s.fol = '0; s.has = 1'b0;
    if (c >= CP_KA && c <= CP_BASE_HI) return 1;
    if (c == CP_COENG) return 2;
    return (seg_rank(s) < 100) ? 3 : 0;
  endfunction

  function automatic void put_part(logic [CP_W-1:0] c, logic [CP_W-1:0] f, logic h);
    out_item_t o;
    o.part_code_point = c; o.follow_code_point = f; o.has_follow = h; o.last_of_run = 0;
    if (run_parts.size() < MAX_RESULTS) run_parts.push_back(o);
  endfunction

  function automatic void close_cluster();
    seg_t t;
    int   j;
    for (int i = 2; i < cluster_len; i++) begin
      t = cluster[i];
      j = i;
      // stable insertion sort behind the first part
      while (j > 1 && (seg_rank(cluster[j-1]) > seg_rank(t) ||
             (seg_rank(cluster[j-1]) == seg_rank(t) && cluster[j-1].cp > t.cp))) begin
        cluster[j] = cluster[j-1];
        j--;
      end
      cluster[j] = t;
    end
    for (int i = 0; i < cluster_len; i++)
      put_part(cluster[i].cp, cluster[i].fol, cluster[i].has);
    cluster_len = 0;
  endfunction

  function automatic void append(logic [CP_W-1:0] c, logic [CP_W-1:0] f, logic h);
    if (cluster_len >= 64) close_cluster();
    cluster[cluster_len].cp = c;
    cluster[cluster_len].fol = f;
    cluster[cluster_len].has = h;
    cluster_len++;
  endfunction

  function automatic void place(logic [CP_W-1:0] c, logic [CP_W-1:0] f, logic h);
    int k;
    k = cp_kind(c);
    if (k == 1) begin
      close_cluster();
      append(c, '0, 1'b0);
    end else if (k == 2) begin
      append(c, f, h);
    end else if (k == 3) begin
      if (cluster_len > 0) append(c, '0, 1'b0);
      else put_part(c, '0, 1'b0);
    end else begin
      close_cluster();
      put_part(c, '0, 1'b0);
    end
    if (cluster_len >= MAX_PARTS) close_cluster();
  endfunction

  function automatic void drop_coeng();
    held_state = HELD_NONE;
    held_cp    = '0;
    place(CP_COENG, '0, 1'b0);
  endfunction

  function automatic void join_cp(logic [CP_W-1:0] c);
    if (held_state == HELD_COENG) begin
      if (c >= CP_KA && c <= CP_QA) begin
        held_state = HELD_NONE;
        held_cp    = '0;
        place(CP_COENG, c, 1'b1);
        return;
      end
      drop_coeng();
    end
    if (c == CP_COENG) begin
      held_state = HELD_COENG;
      held_cp    = CP_COENG;
    end else begin
      place(c, '0, 1'b0);
    end
  endfunction

  function automatic void normalize(in_item_t it);
    logic [CP_W-1:0] c;
    c = it.code_point;
    run_parts.delete();
    if (held_state == HELD_E) begin
      held_state = HELD_NONE;
      held_cp    = '0;
      if (c == CP_I) begin join_cp(CP_OE); c = CP_ZWSP; end
      else if (c == CP_AA) begin join_cp(CP_AU); c = CP_ZWSP; end
      else join_cp(CP_E);
    end
    if (c != CP_ZWSP) begin
      if (c == CP_E) begin
        if (held_state == HELD_COENG) drop_coeng();
        held_state = HELD_E;
        held_cp    = CP_E;
      end else begin
        join_cp(c);
      end
    end
    if (it.end_of_text) begin
      if (held_state == HELD_E) begin
        held_state = HELD_NONE;
        held_cp    = '0;
        join_cp(CP_E);
      end else if (held_state == HELD_COENG) begin
        drop_coeng();
      end
      close_cluster();
    end
    if (run_parts.size() > 0) run_parts[run_parts.size()-1].last_of_run = 1'b1;
    foreach (run_parts[i]) parts_due.push_back(run_parts[i]);
  endfunction

  out_item_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_len   = 0;
      held_state    = HELD_NONE;
      held_cp       = '0;
      fail_count_o <= 0;
      parts_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (parts_due.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected part %h", $realtime, out_item_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = parts_due.pop_front();
          if (want !== out_item_i) begin
            if (fail_count_o < 10)
              $display({"%0t: part mismatch exp cp=%h fol=%h has=%b last=%b",
                        " got cp=%h fol=%h has=%b last=%b"},
                       $realtime, want.part_code_point, want.follow_code_point,
                       want.has_follow, want.last_of_run, out_item_i.part_code_point,
                       out_item_i.follow_code_point, out_item_i.has_follow,
                       out_item_i.last_of_run);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // blocking updates inside functions; state is only touched here
      if (in_valid_i && in_ready_i) normalize(in_item_i);
    end
  end

  assign pending_o = parts_due.size();

endmodule

### tb/khmer_cluster_normalizer_tb.sv
`timescale 1ns / 1ps
module khmer_cluster_normalizer_tb;
  import kcn_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;
  int        fail_count;
  int        pending;

  int  send_idle_pct;   // percent of cycles the sender idles
  int  recv_idle_pct;   // percent of cycles the receiver stalls
  bit  hold_off;        // long receiver stall request
  int  quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  khmer_cluster_normalizer u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  khmer_cluster_normalizer_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_item_i(out_item_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, or a solid stall while hold_off is up
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: cycles with no accepted item on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one item on the input channel; valid stays up across back-to-back items
  task automatic send_cp(input logic [CP_W-1:0] c, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{code_point: c, end_of_text: eot};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic [CP_W-1:0] pick_cp();
    case ($urandom_range(15))
      0, 1, 2: return CP_KA + CP_W'($urandom_range(35));   // consonants plus one further base
      3:       return CP_KA + CP_W'($urandom_range(51));   // any base
      4, 5:    return CP_COENG;
      6:       return CP_RO;
      7:       return CP_E;
      8:       return $urandom_range(1) ? CP_I : CP_AA;
      9:       return CP_AA + CP_W'($urandom_range(15));   // vowels
      10:      return $urandom_range(1) ? CP_REG_A : CP_REG_B;
      11:      return CP_SIGN_LO + CP_W'($urandom_range(11));
      12:      return $urandom_range(1) ? CP_SIGN_X : CP_SIGN_Y;
      13:      return CP_ZWSP;
      14:      return CP_W'($urandom_range(21'h1FFFFF));   // anything, out of range too
      default: return CP_W'($urandom_range(21'h17FF, 21'h1700));
    endcase
  endfunction

  // wellformed-ish syllable: base, optional coeng+consonant runs, modifiers
  task automatic send_syllable();
    int n;
    send_cp(CP_KA + CP_W'($urandom_range(34)), 1'b0);
    n = $urandom_range(3);
    repeat (n) begin
      send_cp(CP_COENG, 1'b0);
      send_cp($urandom_range(3) == 0 ? CP_RO : CP_KA + CP_W'($urandom_range(34)), 1'b0);
    end
    n = $urandom_range(3);
    repeat (n) send_cp(pick_cp(), 1'b0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off      = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reordering, composition, coeng rules, extremes
    send_cp(CP_KA, 1'b0); send_cp(CP_SIGN_LO, 1'b0); send_cp(CP_REG_A, 1'b0);
    send_cp(CP_COENG, 1'b0); send_cp(CP_RO, 1'b0); send_cp(CP_COENG, 1'b0);
    send_cp(CP_KA, 1'b0); send_cp(CP_E, 1'b0); send_cp(CP_I, 1'b0);
    send_cp(CP_E, 1'b0); send_cp(CP_AA, 1'b0);
    send_cp(CP_E, 1'b0); send_cp(CP_ZWSP, 1'b0); send_cp(CP_COENG, 1'b0);
    send_cp(CP_ZWSP, 1'b0); send_cp(CP_QA, 1'b0); send_cp(CP_COENG, 1'b0);
    send_cp(CP_E, 1'b0); send_cp(CP_COENG, 1'b0); send_cp(21'h1FFFFF, 1'b0);
    send_cp(CP_SIGN_Y, 1'b0); send_cp(CP_VOW_HI, 1'b0); send_cp(21'h000000, 1'b0);
    send_cp(CP_COENG, 1'b1); send_cp(CP_E, 1'b1);
    drain();

    // full store: base followed by many signs
    send_cp(CP_BASE_HI, 1'b0);
    repeat (70) send_cp(CP_SIGN_X, 1'b0);
    send_cp(CP_KA, 1'b1);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 58 : 0;
      recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 30 : 0;
      if (ph == 2) begin
        // long receiver stall while the sender keeps going
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk_i);
            hold_off = 0;
          end
          repeat (6) send_syllable();
        join
      end
      for (int k = 0; k < 22; k++) begin
        if ($urandom_range(4) != 0) send_syllable();
        else repeat ($urandom_range(4, 1)) send_cp(pick_cp(), 1'b0);
        if ($urandom_range(9) == 0) send_cp(pick_cp(), 1'b1);
      end
      send_cp(pick_cp(), 1'b1);
    end

    drain();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/kcn_pkg.sv
src/kcn_ram.sv
src/kcn_out.sv
src/kcn_seq.sv
src/khmer_cluster_normalizer.sv
src/kcn_checker.sv
tb/khmer_cluster_normalizer_checker.sv
tb/khmer_cluster_normalizer_tb.sv
